FILE: sv/skt_pkg.sv
`default_nettype none

package skt_pkg;

    // Request codes carried on the req_type field.
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_COMMIT
    } t_state;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic capture;   // register the compare results against the request key
        logic or_equal;  // compare as key <= request key instead of key < request key
        logic shift;     // open a slot at the boundary and move the upper cells up by one
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: sv/skt_cell.sv
`default_nettype none

module skt_cell #(
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16,
    parameter int POS_W    = 9,
    parameter int INDEX    = 0
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire skt_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [KEY_BITS-1:0] i_key,
    input  wire logic [TAG_BITS-1:0] i_tag,
    input  wire logic [POS_W-1:0]    i_count,
    input  wire logic                i_left_flag,
    input  wire logic [KEY_BITS-1:0] i_left_key,
    input  wire logic [TAG_BITS-1:0] i_left_tag,
    output logic                     o_flag,
    output logic                     o_bound,
    output logic                     o_hit,
    output logic [KEY_BITS-1:0]      o_key,
    output logic [TAG_BITS-1:0]      o_tag
);
    import skt_pkg::*;

    localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_flag;
    logic                r_eq;
    logic                w_valid;
    logic                w_at_edge;
    logic                n_flag;
    logic                n_eq;

    // A cell holds a record when its place is below the fill count.
    assign w_valid   = i_count > IDX;
    // The first cell, or a cell whose left neighbor lies below the boundary.
    assign w_at_edge = (INDEX == 0) || i_left_flag;

    always_comb begin
        n_eq   = w_valid && (r_key == i_key);
        n_flag = w_valid && (i_ctrl.or_equal ? (r_key <= i_key) : (r_key < i_key));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
            r_eq   <= 1'b0;
        end else if (i_ctrl.capture) begin
            r_flag <= n_flag;
            r_eq   <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift && !r_flag) begin
            if (w_at_edge) begin
                r_key <= i_key;
                r_tag <= i_tag;
            end else begin
                r_key <= i_left_key;
                r_tag <= i_left_tag;
            end
        end
    end

    assign o_flag  = r_flag;
    assign o_bound = w_at_edge && !r_flag;
    // First equal record: the boundary cell, when its key equals the request key.
    assign o_hit   = r_eq && w_at_edge && !r_flag;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

`default_nettype wire

FILE: sv/sorted_key_table_first_match.sv
// The request is registered on acceptance, compared in ST_COMPARE and committed in ST_COMMIT.
// A new transaction is accepted only in ST_IDLE; the sequencer holds one request
// at a time while the cell chain compares in parallel and then shifts.
// A stalled result holds the commit step until the output register is free.
// Reset empties the table (fill count zero) and clears all handshake state;
// the stored keys and tags are not cleared.
`default_nettype none

module sorted_key_table_first_match #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32,
    parameter int TAG_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_req_type,
    input  wire logic [KEY_BITS-1:0]                i_key,
    input  wire logic [TAG_BITS-1:0]                i_record_tag,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_found,
    output logic                                    o_table_full,
    output logic [$clog2(CAPACITY+1)-1:0]           o_position,
    output logic [TAG_BITS-1:0]                     o_match_tag,
    output logic [$clog2(CAPACITY+1)-1:0]           o_entry_count
);
    import skt_pkg::*;

    localparam int POS_W = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    t_state              r_state;
    t_state              n_state;
    t_cell_ctrl          w_ctrl;
    logic                r_req;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [POS_W-1:0]    r_count;
    logic                r_out_valid;
    logic                r_found;
    logic                r_full;
    logic [POS_W-1:0]    r_position;
    logic [TAG_BITS-1:0] r_match_tag;

    logic [CAPACITY-1:0] w_flag;
    logic [CAPACITY-1:0] w_bound;
    logic [CAPACITY-1:0] w_hit;
    logic [KEY_BITS-1:0] w_cell_key [CAPACITY];
    logic [TAG_BITS-1:0] w_cell_tag [CAPACITY];

    logic                w_accept;
    logic                w_out_free;
    logic                w_commit;
    logic                w_is_full;
    logic [POS_W-1:0]    w_bound_pos;
    logic [TAG_BITS-1:0] w_hit_tag;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                skt_cell #(
                    .KEY_BITS (KEY_BITS),
                    .TAG_BITS (TAG_BITS),
                    .POS_W    (POS_W),
                    .INDEX    (g)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctrl      (w_ctrl),
                    .i_key       (r_key),
                    .i_tag       (r_tag),
                    .i_count     (r_count),
                    .i_left_flag (1'b0),
                    .i_left_key  ('0),
                    .i_left_tag  ('0),
                    .o_flag      (w_flag[g]),
                    .o_bound     (w_bound[g]),
                    .o_hit       (w_hit[g]),
                    .o_key       (w_cell_key[g]),
                    .o_tag       (w_cell_tag[g])
                );
            end else begin : g_rest
                skt_cell #(
                    .KEY_BITS (KEY_BITS),
                    .TAG_BITS (TAG_BITS),
                    .POS_W    (POS_W),
                    .INDEX    (g)
                ) u_cell (
                    .i_clk       (i_clk),
                    .i_rst_n     (i_rst_n),
                    .i_ctrl      (w_ctrl),
                    .i_key       (r_key),
                    .i_tag       (r_tag),
                    .i_count     (r_count),
                    .i_left_flag (w_flag[g-1]),
                    .i_left_key  (w_cell_key[g-1]),
                    .i_left_tag  (w_cell_tag[g-1]),
                    .o_flag      (w_flag[g]),
                    .o_bound     (w_bound[g]),
                    .o_hit       (w_hit[g]),
                    .o_key       (w_cell_key[g]),
                    .o_tag       (w_cell_tag[g])
                );
            end
        end
    endgenerate

    // The flags form a prefix, so at most one cell is a boundary; when every
    // cell lies below the request key the boundary sits past the last cell.
    always_comb begin
        w_bound_pos = w_flag[CAPACITY-1] ? CAP_POS : '0;
        w_hit_tag   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_bound_pos = w_bound_pos | (w_bound[i] ? POS_W'(i) : '0);
            w_hit_tag   = w_hit_tag | (w_hit[i] ? w_cell_tag[i] : '0);
        end
    end

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_full  = r_count == CAP_POS;
    assign w_commit   = (r_state == ST_COMMIT) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_stall      = 1'b1;
        w_ctrl.capture  = 1'b0;
        w_ctrl.or_equal = r_req == REQ_INSERT;
        w_ctrl.shift    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                w_ctrl.capture = 1'b1;
                n_state        = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    w_ctrl.shift = (r_req == REQ_INSERT) && !w_is_full;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_key <= i_key;
            r_tag <= i_record_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if ((r_req == REQ_INSERT) && !w_is_full) begin
                    r_count <= r_count + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            if (r_req == REQ_INSERT) begin
                r_found     <= 1'b0;
                r_full      <= w_is_full;
                r_position  <= w_is_full ? r_count : w_bound_pos;
                r_match_tag <= '0;
            end else begin
                r_found     <= |w_hit;
                r_full      <= 1'b0;
                r_position  <= w_bound_pos;
                r_match_tag <= w_hit_tag;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_table_full  = r_full;
    assign o_position    = r_position;
    assign o_match_tag   = r_match_tag;
    assign o_entry_count = r_count;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_POS)
        else $error("fill count exceeds capacity");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> $onehot0(w_hit))
        else $error("more than one first-match cell");

    a_single_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) && !w_flag[CAPACITY-1] |-> $onehot(w_bound))
        else $error("boundary is not unique");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1))
        else $error("fill count moved by more than one");

    a_found_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> !o_table_full)
        else $error("result flags both a hit and a dropped insert");
`endif

endmodule

`default_nettype wire
